### sv/swal_pkg.sv
// Shared types, widths and level mapping for the sensor window averaging block.
package swal_pkg;

	localparam int SAMPLE_W       = 10;
	localparam int LEVEL_W        = 4;
	localparam int TOTAL_W        = 16;
	localparam int SWING_TOTAL_W  = 14;
	localparam int DEF_SAMPLE_WINDOW = 50;
	localparam int DEF_SWING_WINDOWS = 10;
	localparam int LEVEL_STEPS    = 9;

	localparam logic [SAMPLE_W-1:0] DUST_STEP   = 10'd80;
	localparam logic [SAMPLE_W-1:0] DUST_LIMIT  = 10'd799;
	localparam logic [SAMPLE_W-1:0] LIGHT_STEP  = 10'd100;
	localparam logic [SAMPLE_W-1:0] LIGHT_LIMIT = 10'd999;
	localparam logic [LEVEL_W-1:0]  LEVEL_MAX   = 4'd10;

	typedef struct packed {
		logic [SAMPLE_W-1:0] dust_sample;
		logic [SAMPLE_W-1:0] light_sample;
		logic [SAMPLE_W-1:0] sound_sample;
	} swal_in_t;

	typedef struct packed {
		logic [SAMPLE_W-1:0] dust_average;
		logic [LEVEL_W-1:0]  dust_level;
		logic [SAMPLE_W-1:0] light_average;
		logic [LEVEL_W-1:0]  light_level;
		logic [SAMPLE_W-1:0] sound_average;
		logic [LEVEL_W-1:0]  sound_level;
		logic                sound_updated;
	} swal_out_t;

	// Level is LEVEL_MAX above the limit, else one plus how many of the first LEVEL_STEPS
	// step multiples it reaches. Callers pass constant steps, so the thresholds fold to constants.
	function automatic logic [LEVEL_W-1:0] level_of(input logic [SAMPLE_W-1:0] avg,
		input logic [SAMPLE_W-1:0] limit, input logic [SAMPLE_W-1:0] step);
		logic [LEVEL_W-1:0]  lvl;
		logic [SAMPLE_W:0]   thr;
		lvl = 4'd1;
		thr = '0;
		if (avg > limit) begin
			lvl = LEVEL_MAX;
		end else begin
			for (int k = 0; k < LEVEL_STEPS; k++) begin
				thr = thr + {1'b0, step};
				if ({1'b0, avg} >= thr) begin
					lvl = lvl + 4'd1;
				end
			end
		end
		return lvl;
	endfunction

endpackage

### sv/sensor_window_average_levels.sv
// Top level of the sensor window averaging block with level mapping.
//
// One input transaction on in_data carries a dust, a light and a sound sample.
// Every input transaction yields exactly one output transaction on out_data with
// the dust and light running averages over the last SAMPLE_WINDOW samples, their
// levels, and the sound average and level, which change only when a transaction
// closes a window of SAMPLE_WINDOW samples (sound_updated marks that one).
// Both channels use valid/ready. Throughput is one transaction per cycle while the
// receiver does not stall. The accepting edge updates the rings and running
// totals; in the cycle after it the totals are divided by their window lengths
// and the levels mapped, and the output register loads the result once the
// receiver has room for it.
// When the receiver stalls, the output register and the stage behind it hold;
// once both are full, in_ready drops until out_ready returns.
// Reset empties the pipeline and returns all averages, the window tracking and
// the sound outputs to zero. The ring memories are not cleared: a fill flag
// makes unwritten slots read as zero until the first window wraps.
module sensor_window_average_levels
	#(
	parameter int SAMPLE_WINDOW = swal_pkg::DEF_SAMPLE_WINDOW,
	parameter int SWING_WINDOWS = swal_pkg::DEF_SWING_WINDOWS
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  swal_pkg::swal_in_t  in_data,
	output logic                out_valid,
	input  logic                out_ready,
	output swal_pkg::swal_out_t out_data
);

	import swal_pkg::*;

	localparam int PW  = $clog2(SAMPLE_WINDOW);
	localparam int SPW = $clog2(SWING_WINDOWS);
	localparam logic [PW-1:0]  LAST_POS = PW'(SAMPLE_WINDOW - 1);
	localparam logic [SPW-1:0] LAST_SP  = SPW'(SWING_WINDOWS - 1);

	logic                     acc;
	logic                     adv_out;
	logic                     v_s1;
	logic                     upd_s1;
	logic                     out_valid_q;
	swal_out_t                out_q;
	swal_out_t                out_nx;

	logic [PW-1:0]            pos_q;
	logic [PW-1:0]            pos_next;
	logic [PW-1:0]            rd_addr;
	logic                     close;
	logic                     fill_q;

	logic [SAMPLE_W-1:0]      dust_mem_q;
	logic [SAMPLE_W-1:0]      light_mem_q;
	logic [SAMPLE_W-1:0]      dust_old;
	logic [SAMPLE_W-1:0]      light_old;
	logic [TOTAL_W-1:0]       dust_total_q;
	logic [TOTAL_W-1:0]       light_total_q;

	logic [SAMPLE_W-1:0]      hi_q;
	logic [SAMPLE_W-1:0]      lo_q;
	logic [SAMPLE_W-1:0]      hi_nx;
	logic [SAMPLE_W-1:0]      lo_nx;
	logic [SAMPLE_W-1:0]      swing;
	logic [SAMPLE_W-1:0]      swing_ring_q [SWING_WINDOWS];
	logic [SWING_TOTAL_W-1:0] swing_total_q;
	logic [SPW-1:0]           sp_q;
	logic                     seen_q;

	logic [SAMPLE_W-1:0]      dust_avg;
	logic [SAMPLE_W-1:0]      light_avg;
	logic [SAMPLE_W-1:0]      sound_avg;

	assign adv_out   = !out_valid_q || out_ready;
	assign in_ready  = !v_s1 || adv_out;
	assign acc       = in_valid && in_ready;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	assign close    = (pos_q == LAST_POS);
	assign pos_next = close ? '0 : pos_q + 1'b1;
	// The read port fetches the slot that the next transaction will overwrite.
	assign rd_addr  = acc ? pos_next : pos_q;

	swal_ring #(.DEPTH(SAMPLE_WINDOW), .W(SAMPLE_W)) u_dust_ring (
		.clk     (clk),
		.wr_en   (acc),
		.wr_addr (pos_q),
		.wr_data (in_data.dust_sample),
		.rd_addr (rd_addr),
		.rd_data (dust_mem_q)
	);

	swal_ring #(.DEPTH(SAMPLE_WINDOW), .W(SAMPLE_W)) u_light_ring (
		.clk     (clk),
		.wr_en   (acc),
		.wr_addr (pos_q),
		.wr_data (in_data.light_sample),
		.rd_addr (rd_addr),
		.rd_data (light_mem_q)
	);

	assign dust_old  = fill_q ? dust_mem_q : '0;
	assign light_old = fill_q ? light_mem_q : '0;

	// The first sample of a window starts the high and low marks afresh.
	assign hi_nx = (pos_q == '0 || in_data.sound_sample > hi_q) ? in_data.sound_sample : hi_q;
	assign lo_nx = (pos_q == '0 || in_data.sound_sample < lo_q) ? in_data.sound_sample : lo_q;
	assign swing = hi_nx - lo_nx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q         <= '0;
			fill_q        <= 1'b0;
			dust_total_q  <= '0;
			light_total_q <= '0;
			hi_q          <= '0;
			lo_q          <= '0;
			swing_total_q <= '0;
			sp_q          <= '0;
			seen_q        <= 1'b0;
			for (int i = 0; i < SWING_WINDOWS; i++) begin
				swing_ring_q[i] <= '0;
			end
		end else if (acc) begin
			pos_q         <= pos_next;
			dust_total_q  <= dust_total_q - TOTAL_W'(dust_old) + TOTAL_W'(in_data.dust_sample);
			light_total_q <= light_total_q - TOTAL_W'(light_old)
				+ TOTAL_W'(in_data.light_sample);
			hi_q          <= hi_nx;
			lo_q          <= lo_nx;
			if (close) begin
				fill_q            <= 1'b1;
				seen_q            <= 1'b1;
				swing_ring_q[sp_q] <= swing;
				swing_total_q     <= swing_total_q - SWING_TOTAL_W'(swing_ring_q[sp_q])
					+ SWING_TOTAL_W'(swing);
				sp_q              <= (sp_q == LAST_SP) ? '0 : sp_q + 1'b1;
			end
		end
	end

	// The state registers double as the first stage: a new transaction enters
	// only when the previous one moves on, so they always match the item in it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1   <= 1'b0;
			upd_s1 <= 1'b0;
		end else if (in_ready) begin
			v_s1   <= in_valid;
			upd_s1 <= close;
		end
	end

	swal_cdiv #(.DIVISOR(SAMPLE_WINDOW), .IN_W(TOTAL_W), .OUT_W(SAMPLE_W)) u_dust_div (
		.num (dust_total_q),
		.quo (dust_avg)
	);

	swal_cdiv #(.DIVISOR(SAMPLE_WINDOW), .IN_W(TOTAL_W), .OUT_W(SAMPLE_W)) u_light_div (
		.num (light_total_q),
		.quo (light_avg)
	);

	swal_cdiv #(.DIVISOR(SWING_WINDOWS), .IN_W(SWING_TOTAL_W), .OUT_W(SAMPLE_W)) u_sound_div (
		.num (swing_total_q),
		.quo (sound_avg)
	);

	always_comb begin
		out_nx.dust_average  = dust_avg;
		out_nx.dust_level    = level_of(dust_avg, DUST_LIMIT, DUST_STEP);
		out_nx.light_average = light_avg;
		out_nx.light_level   = level_of(light_avg, LIGHT_LIMIT, LIGHT_STEP);
		out_nx.sound_average = sound_avg;
		out_nx.sound_level   = seen_q ? level_of(sound_avg, LIGHT_LIMIT, LIGHT_STEP) : '0;
		out_nx.sound_updated = upd_s1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv_out) begin
			out_valid_q <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_out && v_s1) begin
			out_q <= out_nx;
		end
	end

	a_pos_range: assert property (@(posedge clk) disable iff (!arst_n)
		pos_q <= LAST_POS)
		else $error("sample position left the window");

	a_sp_range: assert property (@(posedge clk) disable iff (!arst_n)
		sp_q <= LAST_SP)
		else $error("swing position left the ring");

	a_close_marks: assert property (@(posedge clk) disable iff (!arst_n)
		(acc && close) |=> (v_s1 && upd_s1))
		else $error("window close did not mark the first stage");

	a_level_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_data.dust_level != '0 && out_data.light_level != '0))
		else $error("dust or light level is zero");

	a_sound_level_after_close: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_data.sound_updated) |-> (out_data.sound_level != '0))
		else $error("sound level is zero after a window close");

endmodule

### sv/swal_ring.sv
// Sample ring memory with one write port and one registered read port.
module swal_ring #(
	parameter int DEPTH = swal_pkg::DEF_SAMPLE_WINDOW,
	parameter int W = swal_pkg::SAMPLE_W,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic          clk,
	input  logic          wr_en,
	input  logic [AW-1:0] wr_addr,
	input  logic [W-1:0]  wr_data,
	input  logic [AW-1:0] rd_addr,
	output logic [W-1:0]  rd_data
);

	logic [W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		rd_data <= mem[rd_addr];
	end

endmodule

### sv/swal_cdiv.sv
// Division by a constant through multiplication with a rounded-up reciprocal.
module swal_cdiv #(
	parameter int DIVISOR = swal_pkg::DEF_SAMPLE_WINDOW,
	parameter int IN_W = swal_pkg::TOTAL_W,
	parameter int OUT_W = swal_pkg::SAMPLE_W
) (
	input  logic [IN_W-1:0]  num,
	output logic [OUT_W-1:0] quo
);

	// With a shift of IN_W plus the divisor's rounded-up base-two logarithm the quotient is exact
	// for every numerator of IN_W bits.
	localparam int SH = IN_W + $clog2(DIVISOR);
	localparam int MW = IN_W + 1;
	localparam int PW = IN_W + MW;
	localparam logic [MW-1:0] MULT = MW'(((64'd1 << SH) + 64'(DIVISOR) - 64'd1) / DIVISOR);

	logic [PW-1:0] prod;

	assign prod = {{MW{1'b0}}, num} * {{IN_W{1'b0}}, MULT};
	assign quo  = OUT_W'(prod >> SH);

endmodule

### verif/tb_sensor_window_average_levels.sv
// Self-checking testbench for the sensor window averaging block with level mapping.
module tb_sensor_window_average_levels;
	import swal_pkg::*;

	localparam int WINDOW       = DEF_SAMPLE_WINDOW;
	localparam int SWINGS       = DEF_SWING_WINDOWS;
	localparam int SAMPLE_MAX   = (1 << SAMPLE_W) - 1;
	localparam int STALL_LIMIT  = 2000;
	localparam int DRAIN_CYCLES = 8;

	typedef enum int {SPREAD, STEADY, RAIL_HIGH, RAIL_LOW, NEAR_STEP} level_mode_e;
	typedef enum int {NOISY, QUIET, FULL_SWING, NARROW} sound_mode_e;

	logic      clk       = 1'b0;
	logic      arst_n    = 1'b0;
	logic      in_valid  = 1'b0;
	logic      in_ready;
	swal_in_t  in_data   = '0;
	logic      out_valid;
	logic      out_ready = 1'b0;
	swal_out_t out_data;

	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int mismatches    = 0;
	int quiet_cycles  = 0;

	swal_out_t pending_results[$];

	// Local copy of the block state, tracking every accepted tick.
	logic [SAMPLE_W-1:0]      dust_slots [WINDOW] = '{default: '0};
	logic [SAMPLE_W-1:0]      light_slots [WINDOW] = '{default: '0};
	logic [SAMPLE_W-1:0]      swing_slots [SWINGS] = '{default: '0};
	logic [TOTAL_W-1:0]       dust_sum    = '0;
	logic [TOTAL_W-1:0]       light_sum   = '0;
	logic [SWING_TOTAL_W-1:0] swing_sum   = '0;
	int                       slot        = 0;
	int                       swing_slot  = 0;
	int                       peak        = -1;
	int                       trough      = SAMPLE_MAX + 2;
	logic [SAMPLE_W-1:0]      held_average = '0;
	logic [LEVEL_W-1:0]       held_level   = '0;

	sensor_window_average_levels i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic logic [LEVEL_W-1:0] map_level(input logic [SAMPLE_W-1:0] avg,
		input int limit, input int step);
		if (avg > limit) begin
			return LEVEL_MAX;
		end
		return LEVEL_W'(avg / step + 1);
	endfunction

	function automatic logic [SAMPLE_W-1:0] clamp10(input int v);
		if (v < 0) begin
			return '0;
		end
		if (v > SAMPLE_MAX) begin
			return '1;
		end
		return SAMPLE_W'(v);
	endfunction

	// Advances the local state by one tick and returns the result it should produce.
	function automatic swal_out_t advance_averages(input swal_in_t s);
		swal_out_t           r;
		logic [SAMPLE_W-1:0] swing;
		dust_sum          = dust_sum - dust_slots[slot] + s.dust_sample;
		dust_slots[slot]  = s.dust_sample;
		light_sum         = light_sum - light_slots[slot] + s.light_sample;
		light_slots[slot] = s.light_sample;
		r.dust_average    = SAMPLE_W'(dust_sum / WINDOW);
		r.dust_level      = map_level(r.dust_average, DUST_LIMIT, DUST_STEP);
		r.light_average   = SAMPLE_W'(light_sum / WINDOW);
		r.light_level     = map_level(r.light_average, LIGHT_LIMIT, LIGHT_STEP);
		if (int'(s.sound_sample) > peak) begin
			peak = s.sound_sample;
		end
		if (int'(s.sound_sample) < trough) begin
			trough = s.sound_sample;
		end
		r.sound_updated = 1'b0;
		slot++;
		if (slot >= WINDOW) begin
			swing                   = SAMPLE_W'(peak - trough);
			swing_sum               = swing_sum - swing_slots[swing_slot] + swing;
			swing_slots[swing_slot] = swing;
			held_average            = SAMPLE_W'(swing_sum / SWINGS);
			held_level              = map_level(held_average, LIGHT_LIMIT, LIGHT_STEP);
			swing_slot              = (swing_slot + 1) % SWINGS;
			slot                    = 0;
			peak                    = -1;
			trough                  = SAMPLE_MAX + 2;
			r.sound_updated         = 1'b1;
		end
		r.sound_average = held_average;
		r.sound_level   = held_level;
		return r;
	endfunction

	task automatic report_mismatch(input string what, input int got, input int want);
		$display("mismatch on %s: got %0d, expected %0d at %0t", what, got, want, $time);
		mismatches++;
	endtask

	// Predicts on each accepted input transaction, then checks each accepted result.
	always @(posedge clk) begin
		swal_out_t want;
		if (in_valid && in_ready) begin
			pending_results.push_back(advance_averages(in_data));
		end
		if (out_valid && out_ready) begin
			if (pending_results.size() == 0) begin
				report_mismatch("result with nothing pending", 1, 0);
			end else begin
				want = pending_results.pop_front();
				if (out_data.dust_average !== want.dust_average) begin
					report_mismatch("dust_average", out_data.dust_average, want.dust_average);
				end
				if (out_data.dust_level !== want.dust_level) begin
					report_mismatch("dust_level", out_data.dust_level, want.dust_level);
				end
				if (out_data.light_average !== want.light_average) begin
					report_mismatch("light_average", out_data.light_average,
						want.light_average);
				end
				if (out_data.light_level !== want.light_level) begin
					report_mismatch("light_level", out_data.light_level, want.light_level);
				end
				if (out_data.sound_average !== want.sound_average) begin
					report_mismatch("sound_average", out_data.sound_average,
						want.sound_average);
				end
				if (out_data.sound_level !== want.sound_level) begin
					report_mismatch("sound_level", out_data.sound_level, want.sound_level);
				end
				if (out_data.sound_updated !== want.sound_updated) begin
					report_mismatch("sound_updated", out_data.sound_updated,
						want.sound_updated);
				end
			end
		end
		if ((in_valid && in_ready) || (out_valid && out_ready)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	always @(posedge clk) begin
		out_ready <= ($urandom_range(99) >= recv_idle_pct);
	end

	task automatic send_tick(input logic [SAMPLE_W-1:0] dust, input logic [SAMPLE_W-1:0] light,
		input logic [SAMPLE_W-1:0] sound);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= '{dust_sample: dust, light_sample: light, sound_sample: sound};
		do @(posedge clk); while (!in_ready);
	endtask

	function automatic logic [SAMPLE_W-1:0] pick_level_sample(input level_mode_e mode,
		input int centre);
		case (mode)
			SPREAD: begin
				return SAMPLE_W'($urandom_range(SAMPLE_MAX));
			end
			STEADY: begin
				return clamp10(centre);
			end
			RAIL_HIGH: begin
				return '1;
			end
			RAIL_LOW: begin
				return '0;
			end
			default: begin
				return clamp10(centre + int'($urandom_range(4)) - 2);
			end
		endcase
	endfunction

	// Rails, alternating bits, walking ones on dust and light, a walking zero on sound, then repeated rail ticks.
	task automatic test_corner_ticks();
		send_tick('0, '0, '0);
		send_tick('1, '1, '1);
		send_tick(10'h155, 10'h2AA, 10'h155);
		send_tick(10'h2AA, 10'h155, 10'h2AA);
		for (int b = 0; b < SAMPLE_W; b++) begin
			send_tick(SAMPLE_W'(1 << b), SAMPLE_W'(1 << (SAMPLE_W - 1 - b)), ~SAMPLE_W'(1 << b));
		end
		repeat (6) send_tick('1, '1, '0);
	endtask

	// Each block of one window length gets its own shape per channel, so averages settle
	// onto level boundaries and rails; the sound shape can persist over several windows so
	// that the swing average can reach its own extremes.
	task automatic test_shaped_windows(input int count);
		level_mode_e         dust_mode;
		level_mode_e         light_mode;
		sound_mode_e         sound_mode;
		int                  dust_centre;
		int                  light_centre;
		int                  sound_centre;
		int                  sound_runs;
		logic [SAMPLE_W-1:0] snd;
		dust_mode    = SPREAD;
		light_mode   = SPREAD;
		sound_mode   = NOISY;
		dust_centre  = 0;
		light_centre = 0;
		sound_centre = 0;
		sound_runs   = 0;
		for (int n = 0; n < count; n++) begin
			if (n % WINDOW == 0) begin
				dust_mode   = level_mode_e'($urandom_range(int'(NEAR_STEP)));
				light_mode  = level_mode_e'($urandom_range(int'(NEAR_STEP)));
				dust_centre = $urandom_range(SAMPLE_MAX);
				if (dust_mode == NEAR_STEP) begin
					dust_centre = $urandom_range(1, 10) * DUST_STEP;
				end
				light_centre = $urandom_range(SAMPLE_MAX);
				if (light_mode == NEAR_STEP) begin
					light_centre = $urandom_range(1, 10) * LIGHT_STEP;
				end
				if (sound_runs == 0) begin
					sound_mode = sound_mode_e'($urandom_range(int'(NARROW)));
					sound_runs = $urandom_range(1, 12);
				end
				sound_runs--;
				sound_centre = $urandom_range(SAMPLE_MAX);
			end
			case (sound_mode)
				NOISY: begin
					snd = SAMPLE_W'($urandom_range(SAMPLE_MAX));
				end
				QUIET: begin
					snd = SAMPLE_W'(sound_centre);
				end
				FULL_SWING: begin
					if (n % WINDOW == 7) begin
						snd = '0;
					end else if (n % WINDOW == 31) begin
						snd = '1;
					end else begin
						snd = SAMPLE_W'(sound_centre);
					end
				end
				default: begin
					snd = clamp10(sound_centre + int'($urandom_range(8)) - 4);
				end
			endcase
			send_tick(pick_level_sample(dust_mode, dust_centre),
				pick_level_sample(light_mode, light_centre), snd);
		end
	endtask

	// The sender holds off until the pipeline has emptied, then resumes with full-scale dust, zero light and random sound.
	task automatic test_pause_until_drained();
		in_valid <= 1'b0;
		do @(posedge clk); while (pending_results.size() != 0);
		repeat (25) send_tick('1, '0, SAMPLE_W'($urandom_range(SAMPLE_MAX)));
	endtask

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		send_idle_pct = 10;
		recv_idle_pct = 80;
		test_corner_ticks();
		test_shaped_windows(550);
		test_pause_until_drained();
		send_idle_pct = 80;
		recv_idle_pct = 10;
		test_shaped_windows(550);
		send_idle_pct = 0;
		recv_idle_pct = 0;
		test_shaped_windows(600);
		in_valid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

	// Ends the run when no transaction has moved on either side for too long.
	initial begin
		@(posedge arst_n);
		while (quiet_cycles < STALL_LIMIT) @(posedge clk);
		$display("FAIL");
		$finish;
	end

endmodule
